// ----- hdl/bse_pkg.sv -----
// bubble sort engine package: widths, default depth and sequencer states
// no dependencies; used by every module of the engine
`timescale 1ns / 1ps

package bse_pkg;

   localparam int DATA_W           = 32;
   localparam int MAX_ELEMENTS_DEF = 64;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_FLUSH,
      ST_EMIT
   } state_type;

endpackage

// ----- hdl/bse_mem.sv -----
// element buffer: one write port, one read port with registered read data
// depends on bse_pkg for the data type
`timescale 1ns / 1ps

module bse_mem #(
   parameter int DEPTH = bse_pkg::MAX_ELEMENTS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  bse_pkg::data_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output bse_pkg::data_type rd_data
);

   bse_pkg::data_type store_ff [DEPTH];
   bse_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bse_pass.sv -----
// compare-and-swap unit for one bubble pass: keeps the running maximum,
// writes the smaller element back one slot lower; depends on bse_pkg
`timescale 1ns / 1ps

module bse_pass #(
   parameter int AW = $clog2(bse_pkg::MAX_ELEMENTS_DEF)
) (
   input  logic              clock,
   input  logic              rd_valid,
   input  logic [AW-1:0]     rd_idx,
   input  bse_pkg::data_type rd_data,
   input  logic              flush,
   input  logic [AW-1:0]     flush_addr,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output bse_pkg::data_type wr_data
);

   bse_pkg::data_type carry_ff;
   bse_pkg::data_type carry_in;
   logic              first;
   logic              gt;

   assign first = (rd_idx == '0);
   assign gt    = carry_ff > rd_data;

   always_comb begin
      carry_in = carry_ff;
      wr_en    = 1'b0;
      wr_addr  = flush_addr;
      wr_data  = carry_ff;
      if (rd_valid) begin
         if (first) begin
            carry_in = rd_data;
         end else begin
            wr_en   = 1'b1;
            wr_addr = rd_idx - 1'b1;
            wr_data = gt ? rd_data : carry_ff;
            carry_in = gt ? carry_ff : rd_data;
         end
      end else if (flush) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

endmodule

// ----- hdl/bubble_sort_engine.sv -----
// Batch sorter for signed 32-bit values. Elements are taken one beat per cycle
// and buffered; a beat with req_final_req set closes the batch. A batch of n
// elements is then sorted in place by bubble passes over the buffer memory:
// the pass over the first m entries streams one read and one write per cycle
// through a single compare unit, with m running from n down to 2. Results
// are then read back one at a time, each read waiting until the previous one
// is in the result register and that register is empty or being taken; the
// last one is flagged by rsp_end_of_batch. Input is stalled from the final beat
// until the last result read is issued. Beats beyond MAX_ELEMENTS are dropped
// and every result of that batch carries rsp_overflowed.
// depends on bse_pkg, bse_mem, bse_pass
`timescale 1ns / 1ps

module bubble_sort_engine #(
   parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bse_pkg::data_type req_value,
   input  logic              req_final_req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bse_pkg::data_type rsp_sorted_value,
   output logic              rsp_end_of_batch,
   output logic              rsp_overflowed
);

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   bse_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      emit_idx_ff, emit_idx_in;
   logic               batch_ovf_ff, batch_ovf_in;
   logic               rd_sort_ff, rd_sort_in;
   logic               rd_emit_ff, rd_emit_in;
   logic               rd_last_ff, rd_last_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bse_pkg::data_type  rsp_value_ff, rsp_value_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               room;
   logic [CW-1:0]      cnt_new;
   logic [CW-1:0]      len_dec;
   logic               ld_we;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic               flush;
   logic               pass_we;
   logic [AW-1:0]      pass_waddr;
   bse_pkg::data_type  pass_wdata;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   bse_pkg::data_type  mem_wdata;
   bse_pkg::data_type  mem_rdata;

   assign room    = count_ff < CW'(MAX_ELEMENTS);
   assign cnt_new = room ? count_ff + 1'b1 : count_ff;
   assign len_dec = len_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      emit_idx_in  = emit_idx_ff;
      batch_ovf_in = batch_ovf_ff;
      rd_sort_in   = 1'b0;
      rd_emit_in   = 1'b0;
      rd_last_in   = rd_last_ff;
      rd_idx_in    = rd_idx_ff;
      ld_we        = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[AW-1:0];
      flush        = 1'b0;
      case (state_ff)
         bse_pkg::ST_LOAD: begin
            if (req_valid) begin
               ld_we    = room;
               count_in = cnt_new;
               ovf_in   = ovf_ff | ~room;
               if (req_final_req) begin
                  count_in     = '0;
                  ovf_in       = 1'b0;
                  batch_ovf_in = ovf_ff | ~room;
                  n_in         = cnt_new;
                  len_in       = cnt_new;
                  idx_in       = '0;
                  emit_idx_in  = '0;
                  state_in     = (cnt_new >= CW'(2)) ? bse_pkg::ST_SORT : bse_pkg::ST_EMIT;
               end
            end
         end
         bse_pkg::ST_SORT: begin
            if (idx_ff < len_ff) begin
               mem_re     = 1'b1;
               rd_sort_in = 1'b1;
               rd_idx_in  = idx_ff[AW-1:0];
               idx_in     = idx_ff + 1'b1;
            end else begin
               state_in = bse_pkg::ST_FLUSH;
            end
         end
         bse_pkg::ST_FLUSH: begin
            flush  = 1'b1;
            len_in = len_dec;
            idx_in = '0;
            state_in = (len_dec >= CW'(2)) ? bse_pkg::ST_SORT : bse_pkg::ST_EMIT;
         end
         bse_pkg::ST_EMIT: begin
            mem_raddr = emit_idx_ff[AW-1:0];
            if (!rd_emit_ff && (!rsp_valid_ff || !rsp_stall)) begin
               mem_re      = 1'b1;
               rd_emit_in  = 1'b1;
               rd_last_in  = (emit_idx_ff == n_ff - 1'b1);
               emit_idx_in = emit_idx_ff + 1'b1;
               if (emit_idx_ff == n_ff - 1'b1) begin
                  state_in = bse_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = bse_pkg::ST_LOAD;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rd_emit_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = mem_rdata;
         rsp_end_in   = rd_last_ff;
         rsp_ovf_in   = batch_ovf_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bse_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         emit_idx_ff  <= '0;
         rd_sort_ff   <= 1'b0;
         rd_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         emit_idx_ff  <= emit_idx_in;
         rd_sort_ff   <= rd_sort_in;
         rd_emit_ff   <= rd_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      len_ff       <= len_in;
      batch_ovf_ff <= batch_ovf_in;
      rd_last_ff   <= rd_last_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   bse_pass #(
      .AW(AW)
   ) u_pass (
      .clock      (clock),
      .rd_valid   (rd_sort_ff),
      .rd_idx     (rd_idx_ff),
      .rd_data    (mem_rdata),
      .flush      (flush),
      .flush_addr (len_dec[AW-1:0]),
      .wr_en      (pass_we),
      .wr_addr    (pass_waddr),
      .wr_data    (pass_wdata)
   );

   assign mem_we    = ld_we | pass_we;
   assign mem_waddr = ld_we ? count_ff[AW-1:0] : pass_waddr;
   assign mem_wdata = ld_we ? req_value : pass_wdata;

   bse_mem #(
      .DEPTH(MAX_ELEMENTS),
      .AW   (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_stall        = (state_ff != bse_pkg::ST_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_batch = rsp_end_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

endmodule

// ----- sim/bubble_sort_engine_tb.sv -----
// self-checking bench for bubble_sort_engine: random batches of signed words are sent
// in, sorted results are predicted in the bench and compared beat by beat on the way out
// depends on bse_pkg and bubble_sort_engine
`timescale 1ns / 1ps

module bubble_sort_engine_tb;

   localparam int DEPTH = bse_pkg::MAX_ELEMENTS_DEF;
   localparam int RANDOM_ITEMS = 260;
   localparam int QUIET_TAIL = 40;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 300000;
   localparam bse_pkg::data_type MIN_VAL = 32'h8000_0000;
   localparam bse_pkg::data_type MAX_VAL = 32'h7fff_ffff;

   typedef struct {
      bse_pkg::data_type value;
      logic              last;
   } req_beat_type;

   typedef struct {
      bse_pkg::data_type sorted_value;
      logic              end_of_batch;
      logic              overflowed;
   } sorted_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bse_pkg::data_type req_value = '0;
   logic              req_final_req = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bse_pkg::data_type rsp_sorted_value;
   logic              rsp_end_of_batch;
   logic              rsp_overflowed;

   req_beat_type    pending_beats[$];
   sorted_beat_type sorted_due[$];
   req_beat_type    next_beat;
   sorted_beat_type seen_beat;

   bse_pkg::data_type batch_buf[DEPTH];
   int                batch_len = 0;
   logic              batch_dropped = 1'b0;

   int          errors = 0;
   int          cycles = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic        quiet = 1'b0;

   bubble_sort_engine #(.MAX_ELEMENTS(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_final_req    (req_final_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_batch (rsp_end_of_batch),
      .rsp_overflowed   (rsp_overflowed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, sorted_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // buffer one element; on the closing beat sort the batch and queue its results
   task automatic absorb_element(input bse_pkg::data_type value, input logic last);
      bse_pkg::data_type held;
      sorted_beat_type   res;
      int                n;
      int                pass;
      int                k;
      if (batch_len < DEPTH) begin
         batch_buf[batch_len] = value;
         batch_len++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (last) begin
         n = batch_len;
         for (pass = 0; pass + 1 < n; pass++) begin
            for (k = 0; k + 1 < n - pass; k++) begin
               if (batch_buf[k] > batch_buf[k+1]) begin
                  held = batch_buf[k];
                  batch_buf[k] = batch_buf[k+1];
                  batch_buf[k+1] = held;
               end
            end
         end
         for (k = 0; k < n; k++) begin
            res.sorted_value = batch_buf[k];
            res.end_of_batch = (k == n - 1);
            res.overflowed = batch_dropped;
            sorted_due.push_back(res);
         end
         batch_len = 0;
         batch_dropped = 1'b0;
      end
   endtask

   function automatic bse_pkg::data_type pick_value();
      case ($urandom_range(0, 7))
         0: return MIN_VAL + $urandom_range(0, 2);
         1: return MAX_VAL - $urandom_range(0, 2);
         2, 3: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_beat(input bse_pkg::data_type value, input logic last);
      req_beat_type b;
      b.value = value;
      b.last = last;
      pending_beats.push_back(b);
   endtask

   task automatic add_random_batch(input int n);
      int k;
      for (k = 0; k < n; k++) begin
         push_beat(pick_value(), k == n - 1);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         quiet <= (pending_beats.size() < QUIET_TAIL);
         if (req_valid && !req_stall) begin
            absorb_element(req_value, req_final_req);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 16);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               next_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_value <= next_beat.value;
               req_final_req <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               $display("%0t unexpected beat: expected none, got value %0d last %b ovf %b",
                        $time, rsp_sorted_value, rsp_end_of_batch, rsp_overflowed);
               errors++;
            end else begin
               seen_beat = sorted_due.pop_front();
               if (rsp_sorted_value !== seen_beat.sorted_value) begin
                  $display("%0t sorted_value: expected %0d, got %0d",
                           $time, seen_beat.sorted_value, rsp_sorted_value);
                  errors++;
               end
               if (rsp_end_of_batch !== seen_beat.end_of_batch) begin
                  $display("%0t end_of_batch: expected %b, got %b",
                           $time, seen_beat.end_of_batch, rsp_end_of_batch);
                  errors++;
               end
               if (rsp_overflowed !== seen_beat.overflowed) begin
                  $display("%0t overflowed: expected %b, got %b",
                           $time, seen_beat.overflowed, rsp_overflowed);
                  errors++;
               end
            end
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int counted;
      int batch_idx;
      int n;

      // single elements at both extremes
      push_beat(MIN_VAL, 1'b1);
      push_beat(MAX_VAL, 1'b1);
      // mixed extremes with ties
      push_beat(MAX_VAL, 1'b0);
      push_beat(MIN_VAL, 1'b0);
      push_beat(0, 1'b0);
      push_beat(-1, 1'b0);
      push_beat(1, 1'b0);
      push_beat(MAX_VAL, 1'b0);
      push_beat(MIN_VAL, 1'b0);
      push_beat(0, 1'b1);
      // already ascending
      push_beat(-3, 1'b0);
      push_beat(-2, 1'b0);
      push_beat(-1, 1'b0);
      push_beat(0, 1'b0);
      push_beat(1, 1'b1);
      // descending with a tie
      push_beat(5, 1'b0);
      push_beat(3, 1'b0);
      push_beat(3, 1'b0);
      push_beat(1, 1'b0);
      push_beat(-7, 1'b1);
      // pairs
      push_beat(1, 1'b0);
      push_beat(1, 1'b1);
      push_beat(7, 1'b0);
      push_beat(-7, 1'b1);

      // random batches, one exactly full and one overflowing with its final beat dropped
      counted = 0;
      batch_idx = 0;
      while (counted < RANDOM_ITEMS) begin
         if (batch_idx == 4) begin
            n = DEPTH;
         end else if (batch_idx == 11) begin
            n = DEPTH + $urandom_range(1, 4);
         end else if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(9, 24);
         end else begin
            n = $urandom_range(1, 8);
         end
         add_random_batch(n);
         counted += (n > DEPTH) ? DEPTH : n;
         batch_idx++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid || sorted_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
